// ===== hdl/dfa_csc_pkg.sv =====
// Shared constants for the DFA content sequence checker: word kinds,
// register indexes, field widths and default sizes.
// No dependencies.
package dfa_csc_pkg;

  // default sizes of the stores and of the child counter
  localparam int              DEF_MAX_STATES   = 256;
  localparam int              DEF_MAX_SYMBOLS  = 64;
  localparam longint unsigned DEF_MAX_CHILDREN = 64'd65535;

  // field widths of the input and result words
  localparam int KIND_W   = 3;
  localparam int ID_W     = 32;
  localparam int STIDX_W  = 8;
  localparam int SYMIDX_W = 6;
  localparam int NEXT_W   = 8;
  localparam int FAIL_W   = 16;
  localparam int MAPSZ_W  = 7;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_LOAD_MAP   = 3'd0;
  localparam kind_t KIND_LOAD_TRANS = 3'd1;
  localparam kind_t KIND_LOAD_FINAL = 3'd2;
  localparam kind_t KIND_CHILD      = 3'd3;
  localparam kind_t KIND_END        = 3'd4;

  // register index, taken from paddr[2]
  localparam logic REG_MAP_SIZE = 1'b0;
  localparam logic REG_EMPTY_OK = 1'b1;

endpackage

// ===== hdl/dfa_csc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module dfa_csc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/dfa_csc_symmap.sv =====
// Symbol map of the DFA checker: element id store with one comparator per
// slot, registered match vector and lowest-slot priority encoder.
// Depends on dfa_csc_pkg.
module dfa_csc_symmap #(
  parameter int MAX_SYMBOLS = dfa_csc_pkg::DEF_MAX_SYMBOLS
) (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [$clog2(MAX_SYMBOLS)-1:0]  wr_addr,
  input  logic [dfa_csc_pkg::ID_W-1:0]    wr_data,
  input  logic                            cmp_en,
  input  logic [dfa_csc_pkg::ID_W-1:0]    cmp_id,
  input  logic [dfa_csc_pkg::MAPSZ_W-1:0] limit,
  output logic [$clog2(MAX_SYMBOLS)-1:0]  slot,
  output logic                            hit
);
  import dfa_csc_pkg::*;

  localparam int SYM_AW = $clog2(MAX_SYMBOLS);

  logic [ID_W-1:0]        map_mem [MAX_SYMBOLS];
  logic [MAX_SYMBOLS-1:0] match_vec_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
  end

  // compare every live slot against the child id
  always_ff @(posedge clk) begin
    if (cmp_en) begin
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
        match_vec_r[i] <= (map_mem[i] == cmp_id) && (i < int'(limit));
      end
    end
  end

  // lowest matching slot wins
  always_comb begin
    slot = '0;
    hit  = 1'b0;
    for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
      if (match_vec_r[i]) begin
        slot = SYM_AW'(i);
        hit  = 1'b1;
      end
    end
  end

endmodule

// ===== hdl/dfa_content_sequence_checker.sv =====
// Top level of the DFA content sequence checker: stream input and result
// channels, APB register port, run sequencer.
// Depends on dfa_csc_pkg, dfa_csc_ram and dfa_csc_symmap.
//
// Usage
//   Input words arrive on in_*; in_tuser holds the kind. Load words fill
//   the symbol map, the transition memory and the final-flag memory.
//   Child words step the DFA from state 0; an end word yields one result
//   word on out_* (accepted, fail_index) and restarts the run. The user
//   writes map_size and empty_ok over the APB port while idle; unchecked.
// Timing
//   Load words and ignored kinds are taken in idle and leave it there.
//   A child word is accepted with the map compare, then priority encoded
//   with the transition memory read, then the state update. This
//   read-then-update loop on the transition memory sets the child rate.
//   An end word is accepted with the final-flag read; the verdict state then
//   registers the result word as soon as the result slot is free.
// Reset and stall
//   Reset clears the run state, both registers and the result slot; the
//   memories hold nothing defined until loaded. A stalled receiver holds
//   the result word; loads and children carry on, and a further end word
//   waits in its verdict cycle until the slot is free.
module dfa_content_sequence_checker #(
  parameter int              MAX_STATES   = dfa_csc_pkg::DEF_MAX_STATES,
  parameter int              MAX_SYMBOLS  = dfa_csc_pkg::DEF_MAX_SYMBOLS,
  parameter longint unsigned MAX_CHILDREN = dfa_csc_pkg::DEF_MAX_CHILDREN
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input words
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // elem_id[31:0], state_index[39:32], symbol_index[45:40],
  // next_state[53:46], entry_valid[54], final_flag[55]
  input  logic [dfa_csc_pkg::IN_DATA_W-1:0]  in_tdata,
  // kind[2:0]
  input  logic [dfa_csc_pkg::KIND_W-1:0]     in_tuser,
  // result words
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // accepted[0], fail_index[16:1], zero[23:17]
  output logic [dfa_csc_pkg::OUT_DATA_W-1:0] out_tdata,
  // register port
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [dfa_csc_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [dfa_csc_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [dfa_csc_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                               cfg_pready
);
  import dfa_csc_pkg::*;

  localparam int ST_AW  = $clog2(MAX_STATES);
  localparam int SYM_AW = $clog2(MAX_SYMBOLS);
  localparam int TR_AW  = ST_AW + SYM_AW;
  localparam int CNT_W  = $clog2(MAX_CHILDREN + 64'd1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHILDREN);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;
  localparam logic [1:0] ST_END    = 2'd3;

  // input fields
  kind_t               kind;
  logic [ID_W-1:0]     elem_id;
  logic [STIDX_W-1:0]  state_index;
  logic [SYMIDX_W-1:0] symbol_index;
  logic [NEXT_W-1:0]   next_state;
  logic                entry_valid;
  logic                final_flag;

  assign kind         = in_tuser;
  assign elem_id      = in_tdata[31:0];
  assign state_index  = in_tdata[39:32];
  assign symbol_index = in_tdata[45:40];
  assign next_state   = in_tdata[53:46];
  assign entry_valid  = in_tdata[54];
  assign final_flag   = in_tdata[55];

  logic [1:0]          fsm_r, fsm_nxt;
  logic [NEXT_W-1:0]   cur_state_r, cur_state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                failed_r, failed_nxt;
  logic [CNT_W-1:0]    failed_at_r, failed_at_nxt;
  logic                hit_r, hit_nxt;
  logic                st_ok_r, st_ok_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_acc_r, out_acc_nxt;
  logic [FAIL_W-1:0]   out_fail_r, out_fail_nxt;
  logic [MAPSZ_W-1:0]  map_size_r, map_size_nxt;
  logic                empty_ok_r, empty_ok_nxt;

  logic                in_acc;
  logic                sym_ok, st_ok_in, cur_ok;
  logic                cfg_wr;
  logic [SYM_AW-1:0]   slot;
  logic                hit;
  logic [NEXT_W:0]     trans_rdata;
  logic                final_rdata;
  logic                trans_re;
  logic                final_re;
  logic                out_free;

  assign in_tready = (fsm_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign sym_ok    = int'(symbol_index) < MAX_SYMBOLS;
  assign st_ok_in  = int'(state_index) < MAX_STATES;
  assign cur_ok    = int'(cur_state_r) < MAX_STATES;
  assign out_free  = !out_valid_r || out_tready;

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    case (cfg_paddr[2])
      REG_MAP_SIZE: cfg_prdata = CFG_DW'(map_size_r);
      REG_EMPTY_OK: cfg_prdata = CFG_DW'(empty_ok_r);
      default:      cfg_prdata = '0;
    endcase
  end

  always_comb begin
    map_size_nxt = map_size_r;
    empty_ok_nxt = empty_ok_r;
    if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_MAP_SIZE: map_size_nxt = cfg_pwdata[MAPSZ_W-1:0];
        REG_EMPTY_OK: empty_ok_nxt = cfg_pwdata[0];
        default:      map_size_nxt = map_size_r;
      endcase
    end
  end

  // symbol map: write on a map load, compare on a child
  dfa_csc_symmap #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_symmap (
    .clk     (clk),
    .wr_en   (in_acc && kind == KIND_LOAD_MAP && sym_ok),
    .wr_addr (SYM_AW'(symbol_index)),
    .wr_data (elem_id),
    .cmp_en  (in_acc && kind == KIND_CHILD),
    .cmp_id  (elem_id),
    .limit   (map_size_r),
    .slot    (slot),
    .hit     (hit)
  );

  // transition memory: {valid, next state} at {state, column}
  assign trans_re = (fsm_r == ST_LOOKUP);

  dfa_csc_ram #(
    .WIDTH (NEXT_W + 1),
    .DEPTH (2 ** TR_AW)
  ) u_trans_ram (
    .clk   (clk),
    .we    (in_acc && kind == KIND_LOAD_TRANS && st_ok_in && sym_ok),
    .waddr ({ST_AW'(state_index), SYM_AW'(symbol_index)}),
    .wdata ({entry_valid, next_state}),
    .re    (trans_re),
    .raddr ({ST_AW'(cur_state_r), slot}),
    .rdata (trans_rdata)
  );

  // final-flag memory, read as the end word is taken
  assign final_re = in_acc && kind == KIND_END;

  dfa_csc_ram #(
    .WIDTH (1),
    .DEPTH (2 ** ST_AW)
  ) u_final_ram (
    .clk   (clk),
    .we    (in_acc && kind == KIND_LOAD_FINAL && st_ok_in),
    .waddr (ST_AW'(state_index)),
    .wdata (final_flag),
    .re    (final_re),
    .raddr (ST_AW'(cur_state_r)),
    .rdata (final_rdata)
  );

  // run sequencer
  always_comb begin
    fsm_nxt       = fsm_r;
    cur_state_nxt = cur_state_r;
    count_nxt     = count_r;
    failed_nxt    = failed_r;
    failed_at_nxt = failed_at_r;
    hit_nxt       = hit_r;
    st_ok_nxt     = st_ok_r;
    out_acc_nxt   = out_acc_r;
    out_fail_nxt  = out_fail_r;
    out_valid_nxt = out_valid_r && !out_tready;

    case (fsm_r)
      ST_IDLE: begin
        if (in_acc && kind == KIND_CHILD) begin
          fsm_nxt = ST_LOOKUP;
        end else if (in_acc && kind == KIND_END) begin
          fsm_nxt = ST_END;
        end
      end
      ST_LOOKUP: begin
        // hold the encoder result beside the memory read
        hit_nxt   = hit;
        st_ok_nxt = cur_ok;
        fsm_nxt   = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!failed_r) begin
          if (!hit_r || !st_ok_r || !trans_rdata[NEXT_W]) begin
            failed_nxt    = 1'b1;
            failed_at_nxt = count_r;
          end else begin
            cur_state_nxt = trans_rdata[NEXT_W-1:0];
          end
        end
        if (count_r != CNT_MAX) begin
          count_nxt = count_r + CNT_W'(1);
        end
        fsm_nxt = ST_IDLE;
      end
      ST_END: begin
        // wait here while an earlier verdict is still held
        if (out_free) begin
          if (count_r == '0) begin
            out_acc_nxt  = empty_ok_r;
            out_fail_nxt = '0;
          end else if (failed_r) begin
            out_acc_nxt  = 1'b0;
            out_fail_nxt = FAIL_W'(failed_at_r);
          end else if (!cur_ok || !final_rdata) begin
            out_acc_nxt  = 1'b0;
            out_fail_nxt = FAIL_W'(count_r);
          end else begin
            out_acc_nxt  = 1'b1;
            out_fail_nxt = '0;
          end
          out_valid_nxt = 1'b1;
          cur_state_nxt = '0;
          count_nxt     = '0;
          failed_nxt    = 1'b0;
          failed_at_nxt = '0;
          fsm_nxt       = ST_IDLE;
        end
      end
      default: begin
        fsm_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= ST_IDLE;
      cur_state_r <= '0;
      count_r     <= '0;
      failed_r    <= 1'b0;
      failed_at_r <= '0;
      out_valid_r <= 1'b0;
      map_size_r  <= '0;
      empty_ok_r  <= 1'b0;
    end else begin
      fsm_r       <= fsm_nxt;
      cur_state_r <= cur_state_nxt;
      count_r     <= count_nxt;
      failed_r    <= failed_nxt;
      failed_at_r <= failed_at_nxt;
      out_valid_r <= out_valid_nxt;
      map_size_r  <= map_size_nxt;
      empty_ok_r  <= empty_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r      <= hit_nxt;
    st_ok_r    <= st_ok_nxt;
    out_acc_r  <= out_acc_nxt;
    out_fail_r <= out_fail_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - FAIL_W - 1)'(0), out_fail_r, out_acc_r};

endmodule

// ===== verif/dfa_content_sequence_checker_tb.sv =====
// Self-checking testbench for dfa_content_sequence_checker: directed and random
// load, child and end words against a DFA verdict tracker, with random stalls.
// Depends on dfa_csc_pkg and the RTL of the block.
module dfa_content_sequence_checker_tb;
  import dfa_csc_pkg::*;

  localparam int     CLK_PERIOD    = 10;
  localparam longint RUN_LIMIT     = 3_000_000;  // cycles before the watchdog fires
  localparam int     SETTLE_CYCLES = 8;          // lets a child word still in flight finish
  localparam int     MAX_GAP       = 40;
  localparam int     STATE_POOL    = 8;          // most random DFAs live in states 0..7
  localparam int     ID_POOL       = 8;

  localparam kind_t              KIND_IGNORED_LO  = kind_t'(KIND_END + 1);
  localparam kind_t              KIND_IGNORED_HI  = {KIND_W{1'b1}};

  typedef struct {
    kind_t                kind;
    logic [ID_W-1:0]      elem_id;
    logic [STIDX_W-1:0]   st;
    logic [SYMIDX_W-1:0]  sym;
    logic [NEXT_W-1:0]    nxt;
    logic                 vld;
    logic                 fin;
  } word_t;

  typedef struct {
    bit              accepted;
    bit [FAIL_W-1:0] fail_index;
  } verdict_t;

  // Tracks the stores, the registers and the run state of the checker, and
  // holds the verdicts still owed by the block in arrival order.
  class content_model_tracker;
    bit [ID_W-1:0]    sym_ids     [DEF_MAX_SYMBOLS];
    bit               sym_known   [DEF_MAX_SYMBOLS];
    bit [NEXT_W:0]    trans_mem   [DEF_MAX_STATES * DEF_MAX_SYMBOLS];
    bit               trans_known [DEF_MAX_STATES * DEF_MAX_SYMBOLS];
    bit               finals      [DEF_MAX_STATES];
    bit               final_known [DEF_MAX_STATES];
    bit [MAPSZ_W-1:0] map_size_r;
    bit               empty_ok_r;
    bit [STIDX_W-1:0] cur_state;
    int unsigned      child_cnt;
    bit               failed;
    bit [FAIL_W-1:0]  failed_pos;
    verdict_t         verdicts_due[$];
    int unsigned      errors;

    function void set_reg(logic idx, bit [CFG_DW-1:0] val);
      if (idx == REG_MAP_SIZE) map_size_r = val[MAPSZ_W-1:0];
      else empty_ok_r = val[0];
    endfunction

    // map_size beyond the store depth acts as the full store
    function int unsigned map_limit();
      return (map_size_r > DEF_MAX_SYMBOLS) ? DEF_MAX_SYMBOLS : map_size_r;
    endfunction

    function int unsigned trans_addr(bit [STIDX_W-1:0] st, bit [SYMIDX_W-1:0] col);
      return int'({st, col});
    endfunction

    // lowest matching slot wins
    function bit find_slot(input bit [ID_W-1:0] id, output bit [SYMIDX_W-1:0] slot);
      int unsigned i;
      slot = '0;
      for (i = 0; i < map_limit(); i++) begin
        if (sym_ids[i] == id) begin
          slot = SYMIDX_W'(i);
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void clear_run();
      cur_state  = '0;
      child_cnt  = 0;
      failed     = 1'b0;
      failed_pos = '0;
    endfunction

    function void note_word(word_t w);
      verdict_t            v;
      bit [SYMIDX_W-1:0]   slot;
      bit [NEXT_W:0]       ent;
      case (w.kind)
        KIND_LOAD_MAP: begin
          sym_ids[w.sym]   = w.elem_id;
          sym_known[w.sym] = 1'b1;
        end
        KIND_LOAD_TRANS: begin
          trans_mem[trans_addr(w.st, w.sym)]   = {w.vld, w.nxt};
          trans_known[trans_addr(w.st, w.sym)] = 1'b1;
        end
        KIND_LOAD_FINAL: begin
          finals[w.st]      = w.fin;
          final_known[w.st] = 1'b1;
        end
        KIND_CHILD: begin
          // once failed, children are only counted; with 8-bit states the
          // current state is always inside the table
          if (!failed) begin
            if (!find_slot(w.elem_id, slot)) begin
              failed     = 1'b1;
              failed_pos = child_cnt[FAIL_W-1:0];
            end else begin
              ent = trans_mem[trans_addr(cur_state, slot)];
              if (!ent[NEXT_W]) begin
                failed     = 1'b1;
                failed_pos = child_cnt[FAIL_W-1:0];
              end else begin
                cur_state = ent[NEXT_W-1:0];
              end
            end
          end
          if (child_cnt < DEF_MAX_CHILDREN) child_cnt++;
        end
        KIND_END: begin
          v.fail_index = '0;
          if (child_cnt == 0) begin
            v.accepted = empty_ok_r;
          end else if (failed) begin
            v.accepted   = 1'b0;
            v.fail_index = failed_pos;
          end else if (!finals[cur_state]) begin
            v.accepted   = 1'b0;
            v.fail_index = child_cnt[FAIL_W-1:0];
          end else begin
            v.accepted = 1'b1;
          end
          verdicts_due.push_back(v);
          clear_run();
        end
        default: ;  // unknown kinds leave everything as it is
      endcase
    endfunction

    function void check_verdict(logic [OUT_DATA_W-1:0] d);
      verdict_t v;
      if (verdicts_due.size() == 0) begin
        $error("result word with no verdict outstanding: %h", d);
        errors++;
        return;
      end
      v = verdicts_due.pop_front();
      if (d[0] !== v.accepted) begin
        $error("accepted: expected %0d, got %0d", v.accepted, d[0]);
        errors++;
      end
      if (d[FAIL_W:1] !== v.fail_index) begin
        $error("fail_index: expected %0d, got %0d", v.fail_index, d[FAIL_W:1]);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata    = '0;
  kind_t                  in_tuser    = KIND_LOAD_MAP;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]      cfg_paddr   = '0;
  logic [CFG_DW-1:0]      cfg_pwdata  = '0;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  content_model_tracker   sb;
  bit [ID_W-1:0]          id_pool [ID_POOL];
  int                     send_gap_pct = 34;
  int                     recv_gap_pct = 82;
  int unsigned            words_sent   = 0;

  dfa_content_sequence_checker i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Receiver: stall at random, one decision per cycle.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_gap_pct);
  end

  // Result monitor: values read here are the ones present before the edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_verdict(out_tdata);
  end

  // Present one word, hold it until the handshake, then note it and idle at random.
  // Must be called straight after a rising edge.
  task automatic push_word(input word_t w);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= w.kind;
    in_tdata  <= {w.fin, w.vld, w.nxt, w.sym, w.st, w.elem_id};
    do @(posedge clk); while (!in_tready);
    sb.note_word(w);
    if (w.kind <= KIND_END) words_sent++;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_gap_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send(input kind_t k, input bit [ID_W-1:0] id, input bit [STIDX_W-1:0] st,
                      input bit [SYMIDX_W-1:0] sym, input bit [NEXT_W-1:0] nxt,
                      input bit vld, input bit fin);
    word_t w;
    w.kind    = k;
    w.elem_id = id;
    w.st      = st;
    w.sym     = sym;
    w.nxt     = nxt;
    w.vld     = vld;
    w.fin     = fin;
    push_word(w);
  endtask

  // Drop the input valid and wait until every verdict is in and the block has
  // finished any child still in flight.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, access cycle, then psel and penable low before the next transfer.
  task automatic write_reg(input logic idx, input bit [CFG_DW-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, val);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic word_t noise_word(kind_t k);
    word_t w;
    w.kind    = k;
    w.elem_id = ID_W'($urandom);
    w.st      = STIDX_W'($urandom);
    w.sym     = SYMIDX_W'($urandom);
    w.nxt     = NEXT_W'($urandom);
    w.vld     = 1'($urandom);
    w.fin     = 1'($urandom);
    return w;
  endfunction

  // Ids from a small pool give duplicate map entries and frequent hits.
  function automatic bit [ID_W-1:0] pooled_id();
    if ($urandom_range(99) < 50) return id_pool[$urandom_range(ID_POOL - 1)];
    return ID_W'($urandom);
  endfunction

  function automatic bit [STIDX_W-1:0] pick_state();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return STIDX_W'($urandom_range(STATE_POOL - 1));
    if (r < 90) return {STIDX_W{1'b1}};
    return STIDX_W'($urandom);
  endfunction

  // A load or an ignored word dropped into the middle of a list.
  function automatic word_t stray_word();
    word_t w;
    case ($urandom_range(3))
      0: begin
        w         = noise_word(KIND_LOAD_MAP);
        w.elem_id = pooled_id();
      end
      1: begin
        w    = noise_word(KIND_LOAD_TRANS);
        w.st = pick_state();
      end
      2: begin
        w    = noise_word(KIND_LOAD_FINAL);
        w.st = pick_state();
      end
      default: w = noise_word(kind_t'($urandom_range(KIND_IGNORED_HI, KIND_IGNORED_LO)));
    endcase
    return w;
  endfunction

  // Write every map slot the current map_size will compare against.
  task automatic fill_map();
    word_t       w;
    int unsigned i;
    for (i = 0; i < sb.map_limit(); i++) begin
      if (!sb.sym_known[i]) begin
        w         = noise_word(KIND_LOAD_MAP);
        w.sym     = SYMIDX_W'(i);
        w.elem_id = pooled_id();
        push_word(w);
      end
    end
  endtask

  // One child list closed by an end word. Transitions and final flags are
  // loaded just before the run first needs them, so nothing unwritten is used.
  task automatic run_list();
    word_t              w;
    int unsigned        len, pick, limit, i;
    bit [SYMIDX_W-1:0]  slot;
    bit [ID_W-1:0]      id;
    pick = $urandom_range(99);
    if (pick < 15) len = 0;
    else if (pick < 85) len = $urandom_range(6, 1);
    else len = $urandom_range(40, 7);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(99) < 8) push_word(stray_word());
      limit = sb.map_limit();
      pick  = $urandom_range(99);
      if (pick < 78 && limit > 0) id = sb.sym_ids[$urandom_range(limit - 1)];
      else if (pick < 92) id = pooled_id();
      else id = ID_W'($urandom);
      if (!sb.failed && sb.find_slot(id, slot) &&
          !sb.trans_known[sb.trans_addr(sb.cur_state, slot)]) begin
        w     = noise_word(KIND_LOAD_TRANS);
        w.st  = sb.cur_state;
        w.sym = slot;
        w.vld = ($urandom_range(99) < 85);
        w.nxt = pick_state();
        push_word(w);
      end
      w         = noise_word(KIND_CHILD);
      w.elem_id = id;
      push_word(w);
    end
    if (!sb.failed && sb.child_cnt != 0 && !sb.final_known[sb.cur_state]) begin
      w     = noise_word(KIND_LOAD_FINAL);
      w.st  = sb.cur_state;
      w.fin = ($urandom_range(99) < 60);
      push_word(w);
    end
    push_word(noise_word(KIND_END));
  endtask

  task automatic run_phase(input int unsigned quota, input bit [MAPSZ_W-1:0] msize,
                           input bit eok);
    int unsigned target;
    settle();
    write_reg(REG_MAP_SIZE, CFG_DW'(msize));
    write_reg(REG_EMPTY_OK, CFG_DW'(eok));
    fill_map();
    target = words_sent + quota;
    while (words_sent < target) run_list();
  endtask

  initial begin
    int i;
    sb         = new();
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (i = 2; i < ID_POOL; i++) id_pool[i] = ID_W'($urandom);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty map: every child misses; reserved kinds are dropped
    write_reg(REG_MAP_SIZE, '0);
    write_reg(REG_EMPTY_OK, '0);
    send(KIND_END, '0, '0, '0, '0, 1'b0, 1'b0);
    send(KIND_CHILD, '0, '0, '0, '0, 1'b0, 1'b0);
    send(KIND_END, '0, '0, '0, '0, 1'b0, 1'b0);
    send(KIND_IGNORED_LO, '1, '1, '1, '1, 1'b1, 1'b1);
    send(KIND_IGNORED_HI, '1, '1, '1, '1, 1'b1, 1'b1);

    // map with a duplicated id in slots 1 and 2, plus the top slot
    send(KIND_LOAD_MAP, '0, '0, 6'd0, '0, 1'b0, 1'b0);
    send(KIND_LOAD_MAP, '1, '0, 6'd1, '0, 1'b0, 1'b0);
    send(KIND_LOAD_MAP, '1, '0, 6'd2, '0, 1'b0, 1'b0);
    send(KIND_LOAD_MAP, 32'h1234_5678, '0, 6'd3, '0, 1'b0, 1'b0);
    send(KIND_LOAD_MAP, 32'h8000_0001, '0, '1, '0, 1'b0, 1'b0);
    send(KIND_LOAD_TRANS, '0, 8'd0, 6'd0, '1, 1'b1, 1'b0);
    send(KIND_LOAD_TRANS, '0, '1, 6'd1, 8'd0, 1'b1, 1'b0);
    send(KIND_LOAD_TRANS, '0, '1, 6'd3, 8'hAA, 1'b0, 1'b0);
    send(KIND_LOAD_TRANS, '0, 8'd0, 6'd1, 8'd1, 1'b1, 1'b0);
    send(KIND_LOAD_FINAL, '0, '1, '0, '0, 1'b0, 1'b1);
    send(KIND_LOAD_FINAL, '0, 8'd0, '0, '0, 1'b0, 1'b0);
    send(KIND_LOAD_FINAL, '0, 8'd1, '0, '0, 1'b0, 1'b1);

    settle();
    write_reg(REG_MAP_SIZE, CFG_DW'(4));
    write_reg(REG_EMPTY_OK, CFG_DW'(1));
    // empty list now accepted
    send(KIND_END, '0, '0, '0, '0, 1'b0, 1'b0);
    // 0 -> 255 -> 0 -> 1, accepting; the duplicate id must take slot 1
    send(KIND_CHILD, '0, '0, '0, '0, 1'b0, 1'b0);
    send(KIND_CHILD, '1, '0, '0, '0, 1'b0, 1'b0);
    send(KIND_CHILD, '1, '0, '0, '0, 1'b0, 1'b0);
    send(KIND_END, '0, '0, '0, '0, 1'b0, 1'b0);
    // invalid transition out of state 255 at the second child
    send(KIND_CHILD, '0, '0, '0, '0, 1'b0, 1'b0);
    send(KIND_CHILD, 32'h1234_5678, '0, '0, '0, 1'b0, 1'b0);
    send(KIND_END, '0, '0, '0, '0, 1'b0, 1'b0);
    // ends in non-accepting state 0: fail at the child count
    send(KIND_CHILD, '0, '0, '0, '0, 1'b0, 1'b0);
    send(KIND_CHILD, '1, '0, '0, '0, 1'b0, 1'b0);
    send(KIND_END, '0, '0, '0, '0, 1'b0, 1'b0);

    // sender idles lightly, receiver heavily
    run_phase(130, 7'd17, 1'b0);
    run_phase(130, 7'd1, 1'b1);

    // and the other way round
    send_gap_pct = 82;
    recv_gap_pct = 34;
    run_phase(130, 7'd64, 1'b0);
    run_phase(130, 7'd9, 1'b1);

    // full rate on both sides; map_size above the store depth first
    send_gap_pct = 0;
    recv_gap_pct = 0;
    run_phase(130, {MAPSZ_W{1'b1}}, 1'b1);
    run_phase(130, 7'd40, 1'b0);

    settle();
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog against a hung handshake or a lost result.
  initial begin
    #(CLK_PERIOD * RUN_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== dfa_content_sequence_checker.f =====
hdl/dfa_csc_pkg.sv
hdl/dfa_csc_ram.sv
hdl/dfa_csc_symmap.sv
hdl/dfa_content_sequence_checker.sv
verif/dfa_content_sequence_checker_tb.sv
